@@ hw/rtl/bbt_pkg.sv @@
// Shared types, constants and helpers for the byte block transposer.
package bbt_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_MAX_COLS  = 8;
    localparam int CFG_DIM_RESET = 8;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

    // readout order
    localparam logic MODE_ENC = 1'b0;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // one block store read in flight, tagged for the output queue
    typedef struct packed {
        logic vld;
        logic pad;
        logic last;
    } t_rd_req;

    function automatic int bbt_addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ hw/rtl/bbt_in_if.sv @@
// Input channel: one message byte per item with an end-of-message flag.
interface bbt_in_if
    import bbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ hw/rtl/bbt_out_if.sv @@
// Output channel: one transposed byte per item with a last flag.
interface bbt_out_if
    import bbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ hw/rtl/byte_block_transposer_core.sv @@
// Byte block transposer: fills a block store row-major, reads it out transposed.
// An item is accepted per cycle while a block fills; ready drops while it drains.
// The block store read port sets the drain rate: one result item per cycle when the
// output is ready; each result passes the read-data register and the output queue.
// A block fills with up to N bytes and always drains N items, padded (N = rows * cols).
// Reset (synchronous, active low) restores mode and sizes and clears the fill count;
// the block store is not cleared.
module byte_block_transposer_core
    import bbt_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bbt_in_if.sink                i_in_ch,
    bbt_out_if.source             o_out_ch
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = bbt_addr_w(DEPTH);

    logic              w_ram_we, w_ram_re, w_can_issue;
    logic [AW-1:0]     w_ram_waddr, w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_wdata, w_ram_rdata;
    t_rd_req           w_rd_req;

    bbt_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_ch),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .o_rd_req    (w_rd_req),
        .i_can_issue (w_can_issue)
    );

    bbt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bbt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_req    (w_rd_req),
        .i_rd_data   (w_ram_rdata),
        .o_can_issue (w_can_issue),
        .o_out       (o_out_ch)
    );

`ifndef SYNTHESIS
    // fill and drain never touch the block store in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("block store written and read in the same cycle");

    // a read is issued only with room for its data in the output queue
    a_read_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_req.vld |-> w_can_issue)
        else $error("block store read issued without queue credit");

    // input is held off while a block drains
    a_no_accept_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |-> !i_in_ch.ready)
        else $error("input accepted while block drains");

    // no result item right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_ch.valid)
        else $error("result item shown right after reset");
`endif

endmodule

@@ hw/rtl/bbt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bbt_ram
    import bbt_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
    localparam int AW   = bbt_addr_w(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bbt_ctrl.sv @@
// Configuration registers, block fill and transposed read-address sequencer.
module bbt_ctrl
    import bbt_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int AW      = bbt_addr_w(MAX_ROWS * MAX_COLS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bbt_in_if.sink                i_in,
    output logic                  o_ram_we,
    output logic [AW-1:0]         o_ram_waddr,
    output logic [BYTE_W-1:0]     o_ram_wdata,
    output logic                  o_ram_re,
    output logic [AW-1:0]         o_ram_raddr,
    output t_rd_req               o_rd_req,
    input  logic                  i_can_issue
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int CW       = $clog2(MAX_COLS + 1);
    localparam int MAXD     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DW       = $clog2(MAXD + 1);
    localparam int SW       = $clog2(DEPTH + 1);
    localparam int ROWS_RST = (CFG_DIM_RESET > MAX_ROWS) ? MAX_ROWS : CFG_DIM_RESET;
    localparam int COLS_RST = (CFG_DIM_RESET > MAX_COLS) ? MAX_COLS : CFG_DIM_RESET;

    t_state         r_state, n_state;
    logic           r_mode;
    logic [RW-1:0]  r_rows, n_rows_cl;
    logic [CW-1:0]  r_cols, n_cols_cl;
    logic [SW-1:0]  r_fill, n_fill;
    logic [SW-1:0]  r_blk_len;
    logic           r_eom;
    logic [DW-1:0]  r_outer, r_inner;
    logic [SW-1:0]  r_pos, r_k;
    logic [SW-1:0]  w_size;
    logic [DW-1:0]  w_lim_inner;
    logic [SW-1:0]  w_stride;
    logic           w_acc, w_done, w_issue, w_k_end, w_inner_end;
    logic           w_ready, w_drain;

    // clamp the written block size into range
    always_comb begin
        if (i_cfg_data == '0) begin
            n_rows_cl = RW'(1);
        end else if (32'(i_cfg_data) > MAX_ROWS) begin
            n_rows_cl = RW'(MAX_ROWS);
        end else begin
            n_rows_cl = RW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            n_cols_cl = CW'(1);
        end else if (32'(i_cfg_data) > MAX_COLS) begin
            n_cols_cl = CW'(MAX_COLS);
        end else begin
            n_cols_cl = CW'(i_cfg_data);
        end
    end

    // block geometry for the current mode
    assign w_size      = SW'(r_rows * r_cols);
    assign w_lim_inner = (r_mode == MODE_ENC) ? DW'(r_rows) : DW'(r_cols);
    assign w_stride    = (r_mode == MODE_ENC) ? SW'(r_cols) : SW'(r_rows);

    // fill side
    assign w_acc  = i_in.valid && w_ready;
    assign n_fill = r_fill + SW'(1);
    assign w_done = (n_fill == w_size) || i_in.end_of_message;

    // drain side
    assign w_issue     = w_drain && i_can_issue;
    assign w_k_end     = (r_k == w_size - SW'(1));
    assign w_inner_end = (r_inner == w_lim_inner - DW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL:  if (w_acc && w_done) n_state = ST_DRAIN;
            ST_DRAIN: if (w_issue && w_k_end) n_state = ST_FILL;
            default:  n_state = ST_FILL;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready = 1'b0;
        w_drain = 1'b0;
        unique case (r_state)
            ST_FILL:  w_ready = 1'b1;
            ST_DRAIN: w_drain = 1'b1;
            default:  w_ready = 1'b0;
        endcase
    end

    assign i_in.ready = w_ready;

    // block store ports
    assign o_ram_we      = w_acc;
    assign o_ram_waddr   = r_fill[AW-1:0];
    assign o_ram_wdata   = i_in.data_byte;
    assign o_ram_re      = w_issue;
    assign o_ram_raddr   = r_pos[AW-1:0];
    assign o_rd_req.vld  = w_issue;
    assign o_rd_req.pad  = (r_pos >= r_blk_len);
    assign o_rd_req.last = r_eom && w_k_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
            r_rows <= RW'(ROWS_RST);
            r_cols <= CW'(COLS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_ROWS: r_rows <= n_rows_cl;
                CFG_COLS: r_cols <= n_cols_cl;
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // fill count and readout sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_fill    <= '0;
            r_blk_len <= '0;
            r_eom     <= 1'b0;
            r_outer   <= '0;
            r_inner   <= '0;
            r_pos     <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            // store bytes, close the block when full or at end of message
            if (w_acc) begin
                if (w_done) begin
                    r_fill    <= '0;
                    r_blk_len <= n_fill;
                    r_eom     <= i_in.end_of_message;
                    r_outer   <= '0;
                    r_inner   <= '0;
                    r_pos     <= '0;
                    r_k       <= '0;
                end else begin
                    r_fill <= n_fill;
                end
            end
            // advance the transposed address one entry per read
            if (w_issue) begin
                r_k <= r_k + SW'(1);
                if (w_inner_end) begin
                    r_inner <= '0;
                    r_outer <= r_outer + DW'(1);
                    r_pos   <= SW'(r_outer) + SW'(1);
                end else begin
                    r_inner <= r_inner + DW'(1);
                    r_pos   <= r_pos + w_stride;
                end
            end
            // a size change drops the partial block
            if (i_cfg_we && (i_cfg_idx == CFG_ROWS || i_cfg_idx == CFG_COLS)) begin
                r_fill <= '0;
            end
        end
    end

endmodule

@@ hw/rtl/bbt_outq.sv @@
// Read-data stage and two-entry output queue with read credit.
module bbt_outq
    import bbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rd_req           i_rd_req,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_can_issue,
    bbt_out_if.source         o_out
);

    t_rd_req           r_tag;
    logic [BYTE_W-1:0] r_byte [2];
    logic              r_last [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt, n_cnt;
    logic              w_push, w_pop;
    logic [BYTE_W-1:0] w_byte;

    assign w_push = r_tag.vld;
    assign w_pop  = o_out.valid && o_out.ready;
    assign w_byte = r_tag.pad ? PAD_BYTE : i_rd_data;
    assign n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);

    // allow a new read only if its data will find a free slot
    assign o_can_issue = (n_cnt < 2'd2);

    // track the read that returns next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_rd_req;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_byte[r_wp] <= w_byte;
            r_last[r_wp] <= r_tag.last;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_byte[r_rp];
    assign o_out.out_last = r_last[r_rp];

endmodule
